// File: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file ncca_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ncca_pkg.sv
package ncca_pkg;

	localparam int MAX_CENTERS = 4;
	localparam int MAX_DIMS    = 8;

	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 2;
	localparam int DIM_W   = 3;
	localparam int COORD_W = 16;
	localparam int DIST_W  = 38;
	localparam int COST_W  = 64;
	localparam int CFG_W   = 3;
	localparam int ABS_W   = COORD_W;
	localparam int PROD_W  = 2 * ABS_W;
	localparam int DIM_AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	localparam int S_FIELDS_W = SLOT_W + DIM_W + COORD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = DIST_W + COST_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POINT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// register index (byte address is 4 * index)
	localparam logic [APB_AW-3:0] REG_CENTERS_IN_USE = '0;
	localparam logic [CFG_W-1:0]  CENTERS_RESET      = 3'd3;

	typedef struct packed {
		logic point;
		logic last;
		logic clear;
		logic dim_ok;
	} item_ctl_t;

endpackage

// File: rtl/core/ncca_ram.sv
module ncca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/nearest_center_cost_accumulator.sv
// Streams points against up to MAX_CENTERS loaded centers and keeps the k-means cost.
// Requests with tuser 0 load one center coordinate, tuser 1 carry one point coordinate
// (tlast marks the point's final coordinate), tuser 2 clear the total. One request is
// taken per cycle while not stalled; each point coordinate squares its difference to every
// center in parallel, one 16x16 multiplier per center, and a point's final coordinate
// passes every pipeline register before its result is offered. Center coordinates sit
// in one small RAM per center with a registered read, so a coordinate loaded in one cycle
// is seen by a point coordinate in the next. Running distances saturate at 2^38-1; the
// total saturates at 2^64-1 and cost_saturated then stays set until a clear. Nothing on
// the output side stops input requests until every stage is full.
module nearest_center_cost_accumulator import ncca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// center_slot, coord_index, coord_value, zero fill
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// kind
	input  logic [KIND_W-1:0]    s_axis_tuser,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// point_min_distance, total_cost, zero fill
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// cost_saturated
	output logic [0:0]           m_axis_tuser,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	logic [SLOT_W-1:0]  in_slot;
	logic [DIM_W-1:0]   in_dim;
	logic [COORD_W-1:0] in_value;
	logic               in_dim_ok;
	logic               in_slot_ok;
	logic               accept;
	item_ctl_t          in_ctl;

	logic en2, en3, en4, en_out;

	logic [CFG_W-1:0] cfg_q;

	logic               v_s1;
	item_ctl_t          ctl_s1;
	logic [COORD_W-1:0] value_s1;
	logic [COORD_W-1:0] center_rd [MAX_CENTERS];
	logic [PROD_W-1:0]  prod [MAX_CENTERS];

	logic              v_s2;
	item_ctl_t         ctl_s2;
	logic [PROD_W-1:0] prod_s2 [MAX_CENTERS];
	logic [DIST_W-1:0] partial_q [MAX_CENTERS];
	logic [DIST_W-1:0] upd [MAX_CENTERS];

	logic              v_s3;
	logic              clear_s3;
	logic [DIST_W-1:0] dist_s3 [MAX_CENTERS];
	logic [DIST_W-1:0] best;

	logic              v_s4;
	logic              clear_s4;
	logic [DIST_W-1:0] min_s4;

	logic              out_v_q;
	logic [DIST_W-1:0] min_q;
	logic [COST_W-1:0] cost_q;
	logic              sat_q;
	logic [COST_W:0]   cost_sum;
	logic [COST_W-1:0] cost_next;

	assign in_slot  = s_axis_tdata[SLOT_W-1:0];
	assign in_dim   = s_axis_tdata[SLOT_W+DIM_W-1:SLOT_W];
	assign in_value = s_axis_tdata[S_FIELDS_W-1:SLOT_W+DIM_W];

	assign in_dim_ok  = {1'b0, in_dim} < (DIM_W + 1)'(MAX_DIMS);
	assign in_slot_ok = {1'b0, in_slot} < (SLOT_W + 1)'(MAX_CENTERS);

	assign in_ctl.point  = (s_axis_tuser == KIND_POINT);
	assign in_ctl.last   = (s_axis_tuser == KIND_POINT) && s_axis_tlast;
	assign in_ctl.clear  = (s_axis_tuser == KIND_CLEAR);
	assign in_ctl.dim_ok = in_dim_ok;

	// stall chain: a stage moves when the one after it is empty or moving
	assign en_out        = v_s4 && (!out_v_q || m_axis_tready);
	assign en4           = v_s3 && (!v_s4 || en_out);
	assign en3           = v_s2 && (!v_s3 || en4);
	assign en2           = v_s1 && (!v_s2 || en3);
	assign s_axis_tready = !v_s1 || en2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_CENTERS_IN_USE) ? APB_DW'(cfg_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CENTERS_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[APB_AW-1:2] == REG_CENTERS_IN_USE) begin
			cfg_q <= pwdata[CFG_W-1:0];
		end
	end

	// center store, one RAM per center, read on every accepted request
	for (genvar c = 0; c < MAX_CENTERS; c++) begin : g_center
		logic we;

		assign we = accept && (s_axis_tuser == KIND_LOAD) && in_slot_ok && in_dim_ok
			&& (in_slot == SLOT_W'(c));

		ncca_ram #(
			.WIDTH(COORD_W),
			.DEPTH(MAX_DIMS)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(in_dim[DIM_AW-1:0]),
			.wdata(in_value),
			.re   (accept),
			.raddr(in_dim[DIM_AW-1:0]),
			.rdata(center_rd[c])
		);
	end

	// stage 1: difference, magnitude, square
	always_comb begin
		logic signed [COORD_W:0] diff;
		logic        [COORD_W:0] mag;
		for (int c = 0; c < MAX_CENTERS; c++) begin
			diff = signed'({center_rd[c][COORD_W-1], center_rd[c]})
				- signed'({value_s1[COORD_W-1], value_s1});
			mag = diff[COORD_W] ? (COORD_W + 1)'(-diff) : diff;
			prod[c] = mag[ABS_W-1:0] * mag[ABS_W-1:0];
		end
	end

	// stage 2: saturating accumulate into the running distances
	always_comb begin
		logic [DIST_W:0] sum;
		for (int c = 0; c < MAX_CENTERS; c++) begin
			sum = {1'b0, partial_q[c]} + (DIST_W + 1)'(prod_s2[c]);
			if (!ctl_s2.dim_ok) begin
				upd[c] = partial_q[c];
			end else if (sum[DIST_W]) begin
				upd[c] = '1;
			end else begin
				upd[c] = sum[DIST_W-1:0];
			end
		end
	end

	// stage 3: nearest center among those in use (0 acts as 1, above max as max)
	always_comb begin
		best = dist_s3[0];
		for (int c = 1; c < MAX_CENTERS; c++) begin
			if ((CFG_W + 2)'(c) < {2'b00, cfg_q} && dist_s3[c] < best) begin
				best = dist_s3[c];
			end
		end
	end

	assign cost_sum  = {1'b0, cost_q} + (COST_W + 1)'(min_s4);
	assign cost_next = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
			cost_q  <= '0;
			sat_q   <= 1'b0;
			for (int c = 0; c < MAX_CENTERS; c++) begin
				partial_q[c] <= '0;
			end
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (en2) begin
				v_s1 <= 1'b0;
			end

			if (en2) begin
				v_s2 <= 1'b1;
			end else if (en3) begin
				v_s2 <= 1'b0;
			end

			// only final coordinates and clears go past the accumulator
			if (en3) begin
				v_s3 <= ctl_s2.last || ctl_s2.clear;
				if (ctl_s2.point) begin
					for (int c = 0; c < MAX_CENTERS; c++) begin
						partial_q[c] <= ctl_s2.last ? '0 : upd[c];
					end
				end
			end else if (en4) begin
				v_s3 <= 1'b0;
			end

			if (en4) begin
				v_s4 <= 1'b1;
			end else if (en_out) begin
				v_s4 <= 1'b0;
			end

			if (en_out) begin
				out_v_q <= !clear_s4;
				if (clear_s4) begin
					cost_q <= '0;
					sat_q  <= 1'b0;
				end else begin
					cost_q <= cost_next;
					sat_q  <= sat_q || (cost_next == '1);
				end
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= in_ctl;
			value_s1 <= in_value;
		end
		if (en2) begin
			ctl_s2 <= ctl_s1;
			for (int c = 0; c < MAX_CENTERS; c++) begin
				prod_s2[c] <= prod[c];
			end
		end
		if (en3) begin
			clear_s3 <= ctl_s2.clear;
			for (int c = 0; c < MAX_CENTERS; c++) begin
				dist_s3[c] <= upd[c];
			end
		end
		if (en4) begin
			clear_s4 <= clear_s3;
			min_s4   <= best;
		end
		if (en_out && !clear_s4) begin
			min_q <= min_s4;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), cost_q, min_q};
	assign m_axis_tuser  = sat_q;

endmodule

// File: rtl/core/ncca_checker.sv
`include "assert_macros.svh"

module ncca_checker import ncca_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]           m_axis_tuser,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [APB_AW-1:0]    paddr,
	input logic [APB_DW-1:0]    pwdata,
	input logic [APB_DW-1:0]    prdata,
	input logic                 pready
);

	`CHK_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result changed")

	// the saturation flag and an all-ones total go together
	`CHK_SAME(a_sat_flag, clk, arst_n, m_axis_tvalid,
		m_axis_tuser[0] == (&m_axis_tdata[M_FIELDS_W-1:DIST_W]),
		"cost_saturated disagrees with total_cost")

	// the total already includes this point's distance
	`CHK_SAME(a_min_le_total, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[M_FIELDS_W-1:DIST_W] >= COST_W'(m_axis_tdata[DIST_W-1:0]),
		"total_cost below point_min_distance")

	`CHK_NEXT(a_cfg_readback, clk, arst_n,
		psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_CENTERS_IN_USE,
		paddr[APB_AW-1:2] != REG_CENTERS_IN_USE
			|| prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]),
		"centers_in_use readback mismatch")

endmodule

bind nearest_center_cost_accumulator ncca_checker u_ncca_checker (.*);
